/* design/lsma_pkg.sv */
// ----------------------------------------------------------------------------
// lsma_pkg
// Shared constants for the light-sample moving average: field widths, the
// fixed-point scale, the configuration reset value and the queue depth.
// ----------------------------------------------------------------------------
package lsma_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned AVG_W    = 26;
  localparam int unsigned CFG_W    = 8;

  // Scaled light value is sample * 200; the mean carries 8 fraction bits.
  localparam int unsigned SCALE_W   = 8;
  localparam logic [SCALE_W-1:0] SCALE = 8'd200;
  localparam int unsigned FRAC_BITS = 8;

  // Default window length and reset value of the report period.
  localparam int unsigned WINDOW_DEF = 16;
  localparam logic [CFG_W-1:0] SEND_EVERY_RST = 8'd1;

  // Entries in the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

/* design/lsma_queue.sv */
// ----------------------------------------------------------------------------
// lsma_queue
// Small register queue that carries window jobs from the front to the back,
// so that each side can stall on its own.
// ----------------------------------------------------------------------------
module lsma_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import lsma_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset; the count guards every read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/lsma_front.sv */
// ----------------------------------------------------------------------------
// lsma_front
// Accepts samples, keeps the sample ring, running sum, fill count and report
// period, and hands one job (sum, fill count, report flag) per sample to the
// queue.
// ----------------------------------------------------------------------------
module lsma_front #(
  parameter int unsigned WINDOW = lsma_pkg::WINDOW_DEF,
  localparam int unsigned FILL_W = $clog2(WINDOW + 1),
  localparam int unsigned SUM_W  = lsma_pkg::SAMPLE_W + FILL_W,
  localparam int unsigned JOB_W  = 1 + FILL_W + SUM_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample input.
  input  logic                          push,
  output logic                          full,
  input  logic [lsma_pkg::SAMPLE_W-1:0] sample_i,
  // Configuration write.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsma_pkg::CFG_W-1:0]    cfg_data_i,
  // Job queue.
  output logic                          q_push_o,
  output logic [JOB_W-1:0]              q_data_o,
  input  logic                          q_full_i
);
  import lsma_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Front states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                state_q, state_d;
  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] old_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CFG_W-1:0]    period_q, period_d;
  logic [CFG_W-1:0]    send_every_q;
  logic [CFG_W-1:0]    period_inc;
  logic                window_full;
  logic                report;
  logic                accept;

  // A sample is taken only when the front is idle and the queue has room;
  // the queue can only drain before the job is pushed in the next cycle.
  assign full        = (state_q != ST_IDLE) || q_full_i;
  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  assign window_full = (fill_q == FILL_W'(WINDOW));
  assign period_inc  = period_q + 1'b1;
  assign report      = (period_inc >= send_every_q);

  // Window and period update, done in the cycle after the ring read.
  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    period_d = period_q;
    q_push_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        q_push_o = 1'b1;
        if (window_full) begin
          sum_d = sum_q - SUM_W'(old_q) + SUM_W'(sample_q);
        end else begin
          sum_d  = sum_q + SUM_W'(sample_q);
          fill_d = fill_q + 1'b1;
        end
        slot_d   = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        period_d = report ? '0 : period_inc;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign q_data_o = {report, fill_d, sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_q       <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      period_q     <= '0;
      send_every_q <= SEND_EVERY_RST;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      period_q <= period_d;
      if (cfg_valid_i && cfg_ready_o) begin
        send_every_q <= cfg_data_i;
      end
    end
  end

  // Hold the accepted sample for the update cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
  end

  // Sample ring: read the oldest slot on accept, write the new sample in the
  // update cycle. The oldest slot is read only once the window is full.
  always_ff @(posedge clk_i) begin
    if (accept && window_full) begin
      old_q <= ring_mem[slot_q];
    end
    if (state_q == ST_UPD) begin
      ring_mem[slot_q] <= sample_q;
    end
  end

endmodule

/* design/lsma_back.sv */
// ----------------------------------------------------------------------------
// lsma_back
// Takes window jobs from the queue, scales the sum to Q8 and divides it by
// the fill count with a one-bit-per-cycle restoring divider, then holds the
// result in an output register until it is popped.
// ----------------------------------------------------------------------------
module lsma_back #(
  parameter int unsigned WINDOW = lsma_pkg::WINDOW_DEF,
  localparam int unsigned FILL_W = $clog2(WINDOW + 1),
  localparam int unsigned SUM_W  = lsma_pkg::SAMPLE_W + FILL_W,
  localparam int unsigned JOB_W  = 1 + FILL_W + SUM_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Job queue.
  input  logic                       q_empty_i,
  input  logic [JOB_W-1:0]           q_data_i,
  output logic                       q_pop_o,
  // Result output.
  output logic                       empty,
  input  logic                       pop,
  output logic [lsma_pkg::AVG_W-1:0] average_q8_o,
  output logic                       report_o
);
  import lsma_pkg::*;

  localparam int unsigned PROD_W = SUM_W + SCALE_W;
  localparam int unsigned DIV_W  = PROD_W + FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(DIV_W);

  // Back states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic [FILL_W-1:0] divisor_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              job_report_q;
  logic [AVG_W-1:0]  avg_q;
  logic              report_q;
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  job_sum;
  logic [FILL_W-1:0] job_fill;
  logic [PROD_W-1:0] product;
  logic [FILL_W:0]   rem_shift;
  logic [FILL_W:0]   rem_diff;
  logic              quo_bit;
  logic              load;
  logic              finish;
  logic              out_pop;

  assign job_sum  = q_data_i[SUM_W-1:0];
  assign job_fill = q_data_i[SUM_W +: FILL_W];
  assign product  = PROD_W'(job_sum) * PROD_W'(SCALE);

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign rem_shift = {rem_q, quo_q[DIV_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor_q};
  assign quo_bit   = (rem_shift >= {1'b0, divisor_q});

  assign out_pop = pop && !empty;
  assign empty   = !out_valid_q;
  assign load    = (state_q == ST_IDLE) && !q_empty_i;
  assign finish  = (state_q == ST_DONE) && (!out_valid_q || out_pop);
  assign q_pop_o = load;

  // Divider sequencing.
  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (load) begin
          quo_d   = {product, FRAC_BITS'(0)};
          rem_d   = '0;
          cnt_d   = CNT_W'(DIV_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d = {quo_q[DIV_W-2:0], quo_bit};
        rem_d = quo_bit ? rem_diff[FILL_W-1:0] : rem_shift[FILL_W-1:0];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register is freed by a pop and refilled when a quotient is done.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_pop) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (load) begin
      divisor_q    <= job_fill;
      job_report_q <= q_data_i[JOB_W-1];
    end
    if (finish) begin
      avg_q    <= quo_q[AVG_W-1:0];
      report_q <= job_report_q;
    end
  end

  assign average_q8_o = avg_q;
  assign report_o     = report_q;

endmodule

/* design/light_sample_moving_average.sv */
// ----------------------------------------------------------------------------
// light_sample_moving_average
// Boxcar moving average of light-sensor samples scaled by 200, reported as
// unsigned Q8 over the samples held so far, with a periodic report flag.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ----------------------------------
//   sample    push / full             sample_i[9:0]
//   result    empty / pop             average_q8_o[25:0], report_o
//   config    cfg_valid_i / cfg_ready_o   cfg_data_i[7:0] (send_every)
//
// The front takes one sample at a time (ring read, then update). The back
// loads a job, runs the serial divide and hands the quotient to the output
// register before it loads the next, so the serial divider sets the rate.
// Reset clears all control state and the running sum at once; the sample ring
// has no reset and no clearing pass. A two-entry queue between front and back
// and the output register let either side stall without losing a request.
// ----------------------------------------------------------------------------
module light_sample_moving_average #(
  parameter int unsigned WINDOW = lsma_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample queue side.
  input  logic                          push,
  output logic                          full,
  input  logic [lsma_pkg::SAMPLE_W-1:0] sample_i,
  // Result queue side.
  output logic                          empty,
  input  logic                          pop,
  output logic [lsma_pkg::AVG_W-1:0]    average_q8_o,
  output logic                          report_o,
  // Configuration write.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsma_pkg::CFG_W-1:0]    cfg_data_i
);
  import lsma_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + FILL_W;
  localparam int unsigned JOB_W  = 1 + FILL_W + SUM_W;

  logic             q_push;
  logic             q_full;
  logic [JOB_W-1:0] q_wdata;
  logic             q_pop;
  logic             q_empty;
  logic [JOB_W-1:0] q_rdata;

  // Front: sample intake, ring store and window bookkeeping.
  lsma_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  // Job queue between the two sides.
  lsma_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // Back: scaling, serial division and result register.
  lsma_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .average_q8_o (average_q8_o),
    .report_o     (report_o)
  );

  // The front never pushes a job into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("job pushed into a full queue");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("job popped from an empty queue");

  // An accepted sample keeps the front busy for its update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push && !full) |=> full)
    else $error("front accepted a sample during its update cycle");

  // An accepted sample produces a job push on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push && !full) |=> q_push)
    else $error("accepted sample did not produce a job");

endmodule
